// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/rrss_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler package
// Payload types, command struct and codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
package rrss_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_LOAD_OK      = 2'd0;
    localparam t_status ST_SLICE        = 2'd1;
    localparam t_status ST_ALL_DONE     = 2'd2;
    localparam t_status ST_LOAD_REFUSED = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam logic [15:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic        func;
        logic [15:0] burst_time;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [2:0]  task_index;
        logic [18:0] slice_end;
        logic [15:0] slice_length;
        logic        task_done;
        logic [18:0] turnaround;
        logic [18:0] waiting;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic load_exec;
        logic slice_exec;
    } t_ctrl_cmd;

endpackage

// ===== design/rrss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler controller
// Sequences the handshakes and issues capture and execute commands.
// ----------------------------------------------------------------------------
module rrss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_func,
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output rrss_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        IDLE  = 3'b001,
        LOAD  = 3'b010,
        SLICE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.load_exec  = 1'b0;
        o_cmd.slice_exec = 1'b0;
        unique case (r_state)
            IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_func == rrss_pkg::FUNC_STEP) ? SLICE : LOAD;
                end
            end
            LOAD: begin
                if (out_free) begin
                    o_cmd.load_exec = 1'b1;
                    n_state = IDLE;
                end
            end
            SLICE: begin
                if (out_free) begin
                    o_cmd.slice_exec = 1'b1;
                    n_state = IDLE;
                end
            end
            default: n_state = IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_exec || o_cmd.slice_exec) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/rrss_dp.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler datapath
// Task memories, work flags, rotating slot search, timing and result register.
// ----------------------------------------------------------------------------
module rrss_dp #(
    parameter int MAX_TASKS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrss_pkg::t_ctrl_cmd i_cmd,
    input  rrss_pkg::t_in_item  i_in_data,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    output rrss_pkg::t_out_item o_out_data
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic [15:0]          mem_rem  [MAX_TASKS];
    logic [15:0]          mem_orig [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_work;

    logic [15:0]          r_quantum;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_ptr;
    logic [19:0]          r_elapsed;
    logic                 r_running;

    logic [15:0]          r_burst;
    logic [IDX_W-1:0]     r_pick;
    logic                 r_found;
    logic [15:0]          r_rem_rd;
    logic [15:0]          r_orig_rd;
    rrss_pkg::t_out_item  r_out;
    rrss_pkg::t_out_item  n_out;

    logic                 hi_found;
    logic                 lo_found;
    logic [IDX_W-1:0]     hi_idx;
    logic [IDX_W-1:0]     lo_idx;
    logic [IDX_W-1:0]     pick;

    logic                 load_ok;
    logic [15:0]          quantum;
    logic [15:0]          len;
    logic [15:0]          rem_new;
    logic [19:0]          elapsed_new;
    logic [19:0]          wait_full;
    logic [CNT_W-1:0]     pick_next;

    always_comb begin
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_idx   = '0;
        lo_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (r_work[i] && (CNT_W'(i) < r_count)) begin
                lo_found = 1'b1;
                lo_idx   = IDX_W'(i);
                if (IDX_W'(i) >= r_ptr) begin
                    hi_found = 1'b1;
                    hi_idx   = IDX_W'(i);
                end
            end
        end
    end

    assign pick = hi_found ? hi_idx : lo_idx;

    assign load_ok     = !r_running && (r_count != CNT_W'(MAX_TASKS));
    assign quantum     = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    assign len         = (r_rem_rd < quantum) ? r_rem_rd : quantum;
    assign rem_new     = r_rem_rd - len;
    assign elapsed_new = r_elapsed + 20'(len);
    assign wait_full   = elapsed_new - 20'(r_orig_rd);
    assign pick_next   = CNT_W'(r_pick) + CNT_W'(1);

    always_comb begin
        n_out = '0;
        if (i_cmd.load_exec) begin
            if (load_ok) begin
                n_out.status     = rrss_pkg::ST_LOAD_OK;
                n_out.task_index = 3'(r_count);
            end else begin
                n_out.status = rrss_pkg::ST_LOAD_REFUSED;
            end
        end else if (r_found) begin
            n_out.status       = rrss_pkg::ST_SLICE;
            n_out.task_index   = 3'(r_pick);
            n_out.slice_end    = elapsed_new[18:0];
            n_out.slice_length = len;
            if (rem_new == 16'd0) begin
                n_out.task_done  = 1'b1;
                n_out.turnaround = elapsed_new[18:0];
                n_out.waiting    = wait_full[18:0];
            end
        end else begin
            n_out.status = rrss_pkg::ST_ALL_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_exec && load_ok) begin
            mem_rem[r_count[IDX_W-1:0]]  <= r_burst;
            mem_orig[r_count[IDX_W-1:0]] <= r_burst;
            r_work[r_count[IDX_W-1:0]]   <= (r_burst != 16'd0);
        end else if (i_cmd.slice_exec && r_found) begin
            mem_rem[r_pick] <= rem_new;
            r_work[r_pick]  <= (rem_new != 16'd0);
        end
        if (i_cmd.capture) begin
            r_rem_rd  <= mem_rem[pick];
            r_orig_rd <= mem_orig[pick];
            r_burst   <= i_in_data.burst_time;
            r_pick    <= pick;
            r_found   <= lo_found;
        end
        if (i_cmd.load_exec || i_cmd.slice_exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrss_pkg::QUANTUM_RESET;
            r_count   <= '0;
            r_ptr     <= '0;
            r_elapsed <= '0;
            r_running <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_quantum <= i_cfg_wr_data;
            end
            if (i_cmd.capture && (i_in_data.func == rrss_pkg::FUNC_STEP)) begin
                r_running <= 1'b1;
            end
            if (i_cmd.load_exec && load_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.slice_exec && r_found) begin
                r_elapsed <= elapsed_new;
                r_ptr     <= (pick_next == r_count) ? '0 : pick_next[IDX_W-1:0];
            end
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== design/round_robin_slice_scheduler.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler
// Loads task bursts into slots and issues round-robin time slices on request.
// ----------------------------------------------------------------------------
// Items are handled one at a time. In the cycle an item is transferred, a
// rotating priority search over the per-slot work flags picks the next task
// and its entries are read from the task memories; in the LOAD or SLICE
// state that follows, once the result register is free, the new or chosen
// entry is written, the elapsed time is advanced for a slice and the result
// register is loaded. The next item may be transferred while a result still
// waits to be taken, and a result waits no longer than the output side stalls.
// The time quantum may be written only while the block is idle.
`include "assert_macros.svh"

module round_robin_slice_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rrss_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rrss_pkg::t_out_item o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data
);

    rrss_pkg::t_ctrl_cmd cmd;

    rrss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in_data.func),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    rrss_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_data    (o_out_data)
    );

    `ASSERT_IMPLIES(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, ##1 o_in_stall)
    `ASSERT_IMPLIES(a_result_follows_item, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))
    `ASSERT_IMPLIES(a_slice_not_empty, i_clk, i_rst_n, o_out_valid && (o_out_data.status == rrss_pkg::ST_SLICE), o_out_data.slice_length != 16'd0)
    `ASSERT_IMPLIES(a_done_turnaround, i_clk, i_rst_n, o_out_valid && o_out_data.task_done, o_out_data.turnaround == o_out_data.slice_end)

endmodule

// ===== tb/tb_round_robin_slice_scheduler.sv =====
// ----------------------------------------------------------------------------
// Round-robin slice scheduler testbench
// Loads task bursts, then requests slices mixed with further loads under a
// series of time quanta, with random sender bursts and receiver stalls, and
// checks every result against a predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_round_robin_slice_scheduler;

    localparam int MAX_SLOTS        = 8;
    localparam int PHASE_COUNT      = 14;
    localparam int ITEMS_PER_PHASE  = 110;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int SETTLE_CYCLES    = 8;

    class rr_slice_predictor;
        logic [15:0]         quantum;
        logic [15:0]         remaining [MAX_SLOTS];
        logic [15:0]         burst_len [MAX_SLOTS];
        int unsigned         loaded;
        int unsigned         rotate_ptr;
        logic [19:0]         elapsed;
        bit                  scheduling;
        rrss_pkg::t_out_item expected_results [$];
        int unsigned         mismatch_count;

        function new();
            quantum = rrss_pkg::QUANTUM_RESET;
            foreach (remaining[i]) begin
                remaining[i] = '0;
                burst_len[i] = '0;
            end
            loaded = 0;
            rotate_ptr = 0;
            elapsed = '0;
            scheduling = 1'b0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        function void note_item(rrss_pkg::t_in_item item);
            rrss_pkg::t_out_item r;
            int unsigned         q;
            int unsigned         pick;
            int unsigned         idx;
            bit                  found;
            logic [15:0]         len;
            logic [19:0]         waited;
            r = '0;
            if (item.func == rrss_pkg::FUNC_LOAD) begin
                if (scheduling || loaded >= MAX_SLOTS) begin
                    r.status = rrss_pkg::ST_LOAD_REFUSED;
                end else begin
                    remaining[loaded] = item.burst_time;
                    burst_len[loaded] = item.burst_time;
                    r.status = rrss_pkg::ST_LOAD_OK;
                    r.task_index = 3'(loaded);
                    loaded++;
                end
            end else begin
                scheduling = 1'b1;
                q = (quantum == 16'd0) ? 1 : quantum;
                found = 1'b0;
                pick = 0;
                for (int k = 0; k < loaded; k++) begin
                    idx = (rotate_ptr + k) % loaded;
                    if (!found && remaining[idx] != 16'd0) begin
                        pick = idx;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = rrss_pkg::ST_ALL_DONE;
                end else begin
                    len = (remaining[pick] < q) ? remaining[pick] : 16'(q);
                    remaining[pick] = remaining[pick] - len;
                    elapsed = elapsed + {4'b0, len};
                    rotate_ptr = (pick + 1) % loaded;
                    r.status = rrss_pkg::ST_SLICE;
                    r.task_index = 3'(pick);
                    r.slice_end = elapsed[18:0];
                    r.slice_length = len;
                    if (remaining[pick] == 16'd0) begin
                        waited = elapsed - {4'b0, burst_len[pick]};
                        r.task_done = 1'b1;
                        r.turnaround = elapsed[18:0];
                        r.waiting = waited[18:0];
                    end
                end
            end
            expected_results.insert(expected_results.size(), r);
        endfunction

        task compare_field(string name, logic [18:0] got, logic [18:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
            end
        endtask

        task check_result(rrss_pkg::t_out_item got);
            rrss_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", 19'(got.status), 19'(want.status));
            compare_field("task_index", 19'(got.task_index), 19'(want.task_index));
            compare_field("slice_end", got.slice_end, want.slice_end);
            compare_field("slice_length", 19'(got.slice_length), 19'(want.slice_length));
            compare_field("task_done", 19'(got.task_done), 19'(want.task_done));
            compare_field("turnaround", got.turnaround, want.turnaround);
            compare_field("waiting", got.waiting, want.waiting);
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    rrss_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_stall;
    rrss_pkg::t_out_item out_data;
    logic                cfg_wr_en;
    logic [15:0]         cfg_wr_data;

    rr_slice_predictor sched_model = new();
    int                burst_left = 0;
    bit                hold_off_request = 1'b0;
    int                quiet_cycles = 0;

    round_robin_slice_scheduler #(
        .MAX_TASKS(MAX_SLOTS)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sched_model.check_result(out_data);
            end
            if (in_valid && !in_stall) begin
                sched_model.note_item(in_data);
            end
            if (cfg_wr_en) begin
                sched_model.quantum = cfg_wr_data;
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL round_robin_slice_scheduler");
                $finish;
            end
        end
    end

    initial begin
        int seg_len;
        int mode;
        int tick;
        out_stall = 1'b0;
        tick = 0;
        forever begin
            if (hold_off_request) begin
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge clk);
                    out_stall = 1'b1;
                end
                hold_off_request = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                seg_len = $urandom_range(10, 120);
                repeat (seg_len) begin
                    @(negedge clk);
                    tick++;
                    case (mode)
                        0: begin
                            out_stall = 1'b0;
                        end
                        1: begin
                            out_stall = ($urandom_range(0, 3) == 0);
                        end
                        2: begin
                            out_stall = (tick % 3 == 0);
                        end
                        default: begin
                            out_stall = ($urandom_range(0, 3) != 0);
                        end
                    endcase
                end
            end
        end
    end

    task automatic offer(input rrss_pkg::t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        in_data = item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic offer_fields(input logic func, input logic [15:0] burst);
        rrss_pkg::t_in_item item;
        item.func = func;
        item.burst_time = burst;
        offer(item);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sched_model.expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [15:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        logic [15:0] quantum;
        logic        func;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        offer_fields(rrss_pkg::FUNC_LOAD, 16'hFFFF);
        offer_fields(rrss_pkg::FUNC_LOAD, 16'h0000);
        offer_fields(rrss_pkg::FUNC_LOAD, 16'd1);
        offer_fields(rrss_pkg::FUNC_LOAD, 16'd4);
        offer_fields(rrss_pkg::FUNC_LOAD, 16'd5);
        repeat (3) offer_fields(rrss_pkg::FUNC_LOAD, 16'($urandom_range(1, 2000)));
        offer_fields(rrss_pkg::FUNC_LOAD, 16'h5A5A);
        repeat (10) offer_fields(rrss_pkg::FUNC_STEP, 16'($urandom));
        offer_fields(rrss_pkg::FUNC_LOAD, 16'h1234);
        drain_results();
        write_quantum(16'd0);
        repeat (4) offer_fields(rrss_pkg::FUNC_STEP, 16'($urandom));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            if (p == 0) begin
                quantum = 16'd1;
            end else if (p == 6) begin
                quantum = 16'd0;
            end else if (p == PHASE_COUNT - 1) begin
                quantum = 16'hFFFF;
            end else begin
                case ($urandom_range(0, 2))
                    0: quantum = 16'($urandom_range(1, 8));
                    1: quantum = 16'($urandom_range(1, 500));
                    default: quantum = 16'($urandom_range(1, 65535));
                endcase
            end
            write_quantum(quantum);
            if (p == 3) begin
                hold_off_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                func = ($urandom_range(0, 9) != 0) ? rrss_pkg::FUNC_STEP : rrss_pkg::FUNC_LOAD;
                offer_fields(func, 16'($urandom));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sched_model.mismatch_count == 0 && sched_model.expected_results.size() == 0) begin
            $display("PASS round_robin_slice_scheduler");
        end else begin
            $display("FAIL round_robin_slice_scheduler");
        end
        $finish;
    end

endmodule
